/* hdl/sbwi_pkg.sv */
// ----------------------------------------------------------------------------
// sbwi_pkg
// types, sizes and command structs for the sorted bone weight insert block
// ----------------------------------------------------------------------------
package sbwi_pkg;

    localparam int VERTICES    = 4096;
    localparam int VTX_BITS    = $clog2(VERTICES);
    localparam int SLOT_COUNT  = 4;
    localparam int SLOT_BITS   = $clog2(SLOT_COUNT);
    localparam int CNT_BITS    = 3;
    localparam int BONE_BITS   = 8;
    localparam int WEIGHT_BITS = 16;

    typedef struct packed {
        logic [VTX_BITS-1:0]    vertex_index;
        logic [BONE_BITS-1:0]   bone_number;
        logic [WEIGHT_BITS-1:0] bone_weight;
    } item_t;

    typedef struct packed {
        logic                   inserted;
        logic [SLOT_BITS-1:0]   insert_slot;
        logic [SLOT_BITS-1:0]   max_slot_passed;
        logic [BONE_BITS-1:0]   slot0_bone;
        logic [BONE_BITS-1:0]   slot1_bone;
        logic [BONE_BITS-1:0]   slot2_bone;
        logic [BONE_BITS-1:0]   slot3_bone;
        logic [WEIGHT_BITS-1:0] slot0_weight;
        logic [WEIGHT_BITS-1:0] slot1_weight;
        logic [WEIGHT_BITS-1:0] slot2_weight;
        logic [WEIGHT_BITS-1:0] slot3_weight;
    } result_t;

    // one vertex entry of the influence store
    typedef struct packed {
        logic [SLOT_COUNT-1:0][BONE_BITS-1:0]   bone;
        logic [SLOT_COUNT-1:0][WEIGHT_BITS-1:0] weight;
    } entry_t;

    // controller to datapath
    typedef struct packed {
        logic                rd_en;
        logic                upd_en;
        logic                clr_en;
        logic [VTX_BITS-1:0] clr_addr;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_free;
    } dp_status_t;

endpackage

/* hdl/sbwi_ctrl.sv */
// ----------------------------------------------------------------------------
// sbwi_ctrl
// sequencer: store clearing after reset, read and update of one vertex entry
// ----------------------------------------------------------------------------
module sbwi_ctrl
    import sbwi_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    output logic       item_stall,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_UPDATE
    } state_t;

    state_t              state_reg, state_next;
    logic [VTX_BITS-1:0] clr_addr_reg, clr_addr_next;
    logic                accept;
    logic                clr_last;

    assign item_stall = (state_reg != ST_IDLE);
    assign accept     = item_valid && (state_reg == ST_IDLE);
    assign clr_last   = (clr_addr_reg == VTX_BITS'(VERTICES - 1));

    always_comb
    begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    always_comb
    begin
        cmd          = '0;
        cmd.rd_en    = accept;
        cmd.upd_en   = (state_reg == ST_UPDATE) && status.out_free;
        cmd.clr_en   = (state_reg == ST_CLEAR);
        cmd.clr_addr = clr_addr_reg;
    end

`ifndef SYNTHESIS
    a_accept_then_update: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_UPDATE))
        else $error("accepted beat not followed by update");

    a_update_waits: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_UPDATE) && !status.out_free) |=> (state_reg == ST_UPDATE))
        else $error("update left while result register busy");

    a_no_clear_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clr_en |-> (!cmd.rd_en && !cmd.upd_en))
        else $error("store access during clearing");
`endif

endmodule

/* hdl/sbwi_datapath.sv */
// ----------------------------------------------------------------------------
// sbwi_datapath
// influence store, sorted insert logic, passed-slot record and result register
// ----------------------------------------------------------------------------
module sbwi_datapath
    import sbwi_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  ctrl_cmd_t           cmd,
    output dp_status_t          status,
    input  item_t               item,
    input  logic                cfg_wr_en,
    input  logic [CNT_BITS-1:0] cfg_wr_data,
    output logic                result_valid,
    input  logic                result_stall,
    output result_t             result
);

    entry_t                 mem [VERTICES];
    entry_t                 rd_data_reg;
    item_t                  item_reg;
    logic [CNT_BITS-1:0]    cfg_reg;
    logic [SLOT_BITS-1:0]   hps_reg, hps_next;
    logic                   out_valid_reg;
    result_t                out_reg;

    logic [CNT_BITS-1:0]    count;
    logic [SLOT_COUNT-1:0]  hit;
    logic                   found;
    logic [SLOT_BITS-1:0]   pos;
    logic                   pass_any;
    logic [SLOT_BITS-1:0]   pass_hi;
    entry_t                 new_entry;

    assign status.out_free = !out_valid_reg || !result_stall;
    assign result_valid    = out_valid_reg;
    assign result          = out_reg;

    // store: clearing sweep or write-back, read on accept
    always_ff @(posedge clk)
    begin
        if (cmd.clr_en)
        begin
            mem[cmd.clr_addr] <= '0;
        end
        else if (cmd.upd_en)
        begin
            mem[item_reg.vertex_index] <= new_entry;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[item.vertex_index];
            item_reg    <= item;
        end
    end

    always_comb
    begin
        count = (cfg_reg > CNT_BITS'(SLOT_COUNT)) ? CNT_BITS'(SLOT_COUNT) : cfg_reg;
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            hit[SLOT_BITS'(i)] = (CNT_BITS'(i) < count)
                  && (item_reg.bone_weight > rd_data_reg.weight[SLOT_BITS'(i)]);
        end
        found = |hit;
        pos   = '0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--)
        begin
            if (hit[SLOT_BITS'(i)])
            begin
                pos = SLOT_BITS'(i);
            end
        end

        // slots scanned without insert
        if (found)
        begin
            pass_any = (pos != '0);
            pass_hi  = pos - 1'b1;
        end
        else
        begin
            pass_any = (count != '0);
            pass_hi  = SLOT_BITS'(count - 1'b1);
        end
        hps_next = (pass_any && (pass_hi > hps_reg)) ? pass_hi : hps_reg;

        new_entry = rd_data_reg;
        if (found && (pos == '0))
        begin
            new_entry.bone[0]   = item_reg.bone_number;
            new_entry.weight[0] = item_reg.bone_weight;
        end
        for (int j = 1; j < SLOT_COUNT; j++)
        begin
            if (found && (CNT_BITS'(j) < count))
            begin
                if (SLOT_BITS'(j) == pos)
                begin
                    new_entry.bone[SLOT_BITS'(j)]   = item_reg.bone_number;
                    new_entry.weight[SLOT_BITS'(j)] = item_reg.bone_weight;
                end
                else if (SLOT_BITS'(j) > pos)
                begin
                    new_entry.bone[SLOT_BITS'(j)]   = rd_data_reg.bone[SLOT_BITS'(j-1)];
                    new_entry.weight[SLOT_BITS'(j)] = rd_data_reg.weight[SLOT_BITS'(j-1)];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg       <= CNT_BITS'(SLOT_COUNT);
            hps_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                cfg_reg <= cfg_wr_data;
            end
            if (cmd.upd_en)
            begin
                hps_reg       <= hps_next;
                out_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.upd_en)
        begin
            out_reg.inserted        <= found;
            out_reg.insert_slot     <= pos;
            out_reg.max_slot_passed <= hps_next;
            out_reg.slot0_bone      <= new_entry.bone[0];
            out_reg.slot1_bone      <= new_entry.bone[1];
            out_reg.slot2_bone      <= new_entry.bone[2];
            out_reg.slot3_bone      <= new_entry.bone[3];
            out_reg.slot0_weight    <= new_entry.weight[0];
            out_reg.slot1_weight    <= new_entry.weight[1];
            out_reg.slot2_weight    <= new_entry.weight[2];
            out_reg.slot3_weight    <= new_entry.weight[3];
        end
    end

`ifndef SYNTHESIS
    a_hps_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        hps_reg >= $past(hps_reg))
        else $error("passed-slot record decreased");

    a_update_loads_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.upd_en |=> out_valid_reg)
        else $error("update did not present a result");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && result_stall) |-> !cmd.upd_en)
        else $error("waiting result overwritten");
`endif

endmodule

/* hdl/sorted_bone_weight_insert_core.sv */
// ----------------------------------------------------------------------------
// sorted_bone_weight_insert_core
// per-vertex top-four bone influences kept sorted by descending weight
// ----------------------------------------------------------------------------
//  channel  | signals                       | direction | beat
//  item     | item_valid, item_stall, item  | in        | vertex, bone, weight
//  result   | result_valid, result_stall,   | out       | insert outcome and
//           | result                        |           | vertex slots after it
//  config   | cfg_wr_en, cfg_wr_data        | in        | slots_in_use write
//
//  an item is accepted with the store read, then compare/shift and write-back
//  follow, set by the single read and single write of the vertex entry
//  after reset the store is swept to zero, one vertex per cycle, all 4096,
//  with item_stall high; configuration writes are taken meanwhile
//  a finished result sits in the output register; the next item is accepted
//  while it waits, and the update of that item holds until the register frees
// ----------------------------------------------------------------------------
module sorted_bone_weight_insert_core
    import sbwi_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    // item channel
    input  logic                item_valid,
    output logic                item_stall,
    input  item_t               item,
    // result channel
    output logic                result_valid,
    input  logic                result_stall,
    output result_t             result,
    // slots_in_use register
    input  logic                cfg_wr_en,
    input  logic [CNT_BITS-1:0] cfg_wr_data
);

    // command and status between sequencer and datapath
    ctrl_cmd_t  cmd;
    dp_status_t status;

    // sequencer: clearing sweep, accept, update
    sbwi_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .status     (status),
        .cmd        (cmd)
    );

    // store, insert logic and result register
    sbwi_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .item         (item),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

/* tb/sv/sbwi_checker.sv */
// ----------------------------------------------------------------------------
// sbwi_checker
// watches the item, result and config channels of the sorted bone weight
// insert core, keeps its own copy of the influence store and compares
// every result beat field by field with the predicted vertex slots
// ----------------------------------------------------------------------------
module sbwi_checker
    import sbwi_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    input  logic                item_stall,
    input  item_t               item,
    input  logic                result_valid,
    input  logic                result_stall,
    input  result_t             result,
    input  logic                cfg_wr_en,
    input  logic [CNT_BITS-1:0] cfg_wr_data,
    output int                  fail_count,
    output int                  pending
);

    logic [BONE_BITS-1:0]   bone_tab   [VERTICES][SLOT_COUNT];
    logic [WEIGHT_BITS-1:0] weight_tab [VERTICES][SLOT_COUNT];
    logic [SLOT_BITS-1:0]   passed_max;
    logic [CNT_BITS-1:0]    slot_limit;
    result_t                expected_slots [$];
    int                     err_tally = 0;

    task automatic report_mismatch(string msg);
        $display("ERROR at %0t: %s", $time, msg);
        err_tally++;
    endtask

    task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
    endtask

    // scan the slots in use, shift below the first lighter one and insert
    function automatic result_t predict_insert(item_t it);
        result_t             r;
        logic [VTX_BITS-1:0] v;
        int                  count;
        int                  i;
        int                  j;
        bit                  hit;
        r     = '0;
        v     = it.vertex_index;
        hit   = 1'b0;
        count = (slot_limit > SLOT_COUNT) ? SLOT_COUNT : int'(slot_limit);
        for (i = 0; i < count && !hit; i++)
        begin
            if (it.bone_weight > weight_tab[v][SLOT_BITS'(i)])
            begin
                for (j = count - 1; j > i; j--)
                begin
                    bone_tab[v][SLOT_BITS'(j)]   = bone_tab[v][SLOT_BITS'(j-1)];
                    weight_tab[v][SLOT_BITS'(j)] = weight_tab[v][SLOT_BITS'(j-1)];
                end
                bone_tab[v][SLOT_BITS'(i)]   = it.bone_number;
                weight_tab[v][SLOT_BITS'(i)] = it.bone_weight;
                r.inserted    = 1'b1;
                r.insert_slot = SLOT_BITS'(i);
                hit           = 1'b1;
            end
            else if (passed_max < i)
                passed_max = SLOT_BITS'(i);
        end
        r.max_slot_passed = passed_max;
        r.slot0_bone      = bone_tab[v][0];
        r.slot1_bone      = bone_tab[v][1];
        r.slot2_bone      = bone_tab[v][2];
        r.slot3_bone      = bone_tab[v][3];
        r.slot0_weight    = weight_tab[v][0];
        r.slot1_weight    = weight_tab[v][1];
        r.slot2_weight    = weight_tab[v][2];
        r.slot3_weight    = weight_tab[v][3];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            for (int v = 0; v < VERTICES; v++)
                for (int s = 0; s < SLOT_COUNT; s++)
                begin
                    bone_tab[VTX_BITS'(v)][SLOT_BITS'(s)]   = '0;
                    weight_tab[VTX_BITS'(v)][SLOT_BITS'(s)] = '0;
                end
            passed_max = '0;
            slot_limit = CNT_BITS'(SLOT_COUNT);
            expected_slots.delete();
        end
        else
        begin
            if (cfg_wr_en)
                slot_limit = cfg_wr_data;
            // compare before queuing, a result never leaves on its own item's edge
            if (result_valid && !result_stall)
            begin
                if (expected_slots.size() == 0)
                    report_mismatch("result beat with no pending expectation");
                else
                begin
                    want = expected_slots.pop_front();
                    check_field("inserted", 32'(result.inserted), 32'(want.inserted));
                    check_field("insert_slot", 32'(result.insert_slot),
                                32'(want.insert_slot));
                    check_field("max_slot_passed", 32'(result.max_slot_passed),
                                32'(want.max_slot_passed));
                    check_field("slot0_bone", 32'(result.slot0_bone),
                                32'(want.slot0_bone));
                    check_field("slot1_bone", 32'(result.slot1_bone),
                                32'(want.slot1_bone));
                    check_field("slot2_bone", 32'(result.slot2_bone),
                                32'(want.slot2_bone));
                    check_field("slot3_bone", 32'(result.slot3_bone),
                                32'(want.slot3_bone));
                    check_field("slot0_weight", 32'(result.slot0_weight),
                                32'(want.slot0_weight));
                    check_field("slot1_weight", 32'(result.slot1_weight),
                                32'(want.slot1_weight));
                    check_field("slot2_weight", 32'(result.slot2_weight),
                                32'(want.slot2_weight));
                    check_field("slot3_weight", 32'(result.slot3_weight),
                                32'(want.slot3_weight));
                end
            end
            if (item_valid && !item_stall)
                expected_slots = {expected_slots, predict_insert(item)};
        end
        fail_count <= err_tally;
        pending    <= expected_slots.size();
    end

endmodule

/* tb/sv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// drives vertex/bone/weight beats into the sorted bone weight insert core
// under random idling and stalls, steps slots_in_use through its range and
// gives the verdict from the failure count of the checker
// ----------------------------------------------------------------------------
module testbench
    import sbwi_pkg::*;
();

    localparam int LIMIT_CYCLES = 400000;  // clear sweep plus slowest run, many times over
    localparam int HOLD_CYCLES  = 300;     // long receiver hold-off to back up the block
    localparam int HOLD_AFTER   = 60;      // results seen before the hold-off starts
    localparam int DRAIN_CYCLES = 4;       // settle time after the last result
    localparam int PHASE_ITEMS  = 90;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                item_valid;
    logic                item_stall;
    item_t               item;
    logic                result_valid;
    logic                result_stall;
    result_t             result;
    logic                cfg_wr_en;
    logic [CNT_BITS-1:0] cfg_wr_data;

    int fail_count;
    int pending;
    int results_seen = 0;
    int cycle_count  = 0;
    bit gaps_on      = 1'b1;

    always #1 clk = ~clk;

    sorted_bone_weight_insert_core DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data)
    );

    sbwi_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    // run limit, covers a hung handshake or a lost result
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // result beats taken, used to time the long hold-off
    always @(posedge clk)
        if (result_valid && !result_stall)
            results_seen <= results_seen + 1;

    // mostly short gaps, a few long ones, none at all when gaps are off
    function automatic int next_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!gaps_on || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // random beat, most of them on a few vertices so the slots fill and shift
    function automatic item_t random_item();
        item_t it;
        int    r;
        r = $urandom_range(0, 9);
        if (r < 7)
            it.vertex_index = VTX_BITS'($urandom_range(0, 15));
        else if (r < 9)
            it.vertex_index = VTX_BITS'($urandom_range(0, VERTICES - 1));
        else
            it.vertex_index = $urandom_range(0, 1) ? '1 : '0;
        it.bone_number = BONE_BITS'($urandom_range(0, 255));
        r = $urandom_range(0, 9);
        if (r < 5)
            it.bone_weight = WEIGHT_BITS'($urandom_range(0, 65535));
        else if (r < 7)
            it.bone_weight = WEIGHT_BITS'($urandom_range(0, 7) * 8192);  // frequent ties
        else if (r == 7)
            it.bone_weight = '0;
        else if (r == 8)
            it.bone_weight = '1;
        else
            it.bone_weight = WEIGHT_BITS'($urandom_range(0, 15));
        return it;
    endfunction

    // offer one beat at the falling edge and hold it until taken
    task automatic send_beat(item_t it);
        int gap;
        @(negedge clk);
        item_valid = 1'b1;
        item       = it;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        gap = next_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            item_valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic send_fields(int vtx, int bone, int weight);
        item_t it;
        it.vertex_index = VTX_BITS'(vtx);
        it.bone_number  = BONE_BITS'(bone);
        it.bone_weight  = WEIGHT_BITS'(weight);
        send_beat(it);
    endtask

    // drop valid, wait for every result, then write the slot count
    task automatic set_slot_limit(int count);
        @(negedge clk);
        item_valid = 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
        cfg_wr_en   = 1'b1;
        cfg_wr_data = CNT_BITS'(count);
        @(negedge clk);
        cfg_wr_en   = 1'b0;
    endtask

    // receiver: random stalls, free-running bursts and one long hold-off
    initial
    begin
        int stall_left;
        int free_left;
        int r;
        bit hold_done;
        stall_left   = 0;
        free_left    = 0;
        hold_done    = 1'b0;
        result_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!hold_done && results_seen >= HOLD_AFTER)
            begin
                // sender keeps offering, the block fills and stalls its input
                hold_done    = 1'b1;
                result_stall = 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                result_stall = 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                result_stall = 1'b1;
            end
            else if (free_left > 0)
            begin
                free_left--;
                result_stall = 1'b0;
            end
            else
            begin
                r            = $urandom_range(0, 99);
                result_stall = 1'b0;
                if (r < 10)
                    free_left = $urandom_range(20, 80);
                else if (r < 55)
                    stall_left = 0;
                else if (r < 90)
                    stall_left = $urandom_range(1, 3);
                else
                    stall_left = $urandom_range(8, 40);
            end
        end
    end

    // sender and verdict
    initial
    begin
        int phase_limits [8];
        rst_n        = 1'b0;
        item_valid   = 1'b0;
        item         = '0;
        cfg_wr_en    = 1'b0;
        cfg_wr_data  = '0;
        phase_limits = '{1, 0, 7, 3, 2, 5, 6, 4};
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // written while the store sweep still runs
        set_slot_limit(4);

        // fill one vertex step by step, ties land after the stored weight
        send_fields(1, 10, 100);
        send_fields(1, 11, 50);
        send_fields(1, 12, 50);
        send_fields(1, 13, 200);
        // lighter than every slot, nothing changes
        send_fields(1, 14, 10);
        // full weight on a full vertex drops the last slot
        send_fields(1, 255, 65535);
        send_fields(1, 0, 0);
        send_fields(1, 20, 65535);
        // zero weight never beats an empty slot
        send_fields(0, 0, 0);
        send_fields(0, 170, 43690);
        send_fields(2, 85, 21845);
        send_fields(4095, 255, 65535);
        send_fields(4095, 0, 1);
        send_fields(4095, 1, 65535);
        send_fields(2730, 3, 32768);
        send_fields(1365, 252, 1);

        for (int n = 0; n < 100; n++)
            send_beat(random_item());

        // slot counts 0 and above four included, 1 leaves the upper slots alone
        foreach (phase_limits[p])
        begin
            set_slot_limit(phase_limits[p]);
            gaps_on = (p % 3 != 1);
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_beat(random_item());
        end

        @(negedge clk);
        item_valid = 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (10) @(posedge clk);

        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
